// File: hdl/splu_pkg.sv
// Shared types and constants for the length-prefixed SPI master.
`timescale 1ns / 1ps

package splu_pkg;

	// Word field widths
	localparam int DATA_W        = 32;
	localparam int BIT_COUNT_W   = 6;
	localparam int HALF_PERIOD_W = 16;

	// Length header sent ahead of the data bits
	localparam int HEADER_BITS   = 8;
	localparam int MAX_BITS_DEF  = 32;

	// Register reset values and fallback length
	localparam logic [BIT_COUNT_W-1:0]   BIT_COUNT_RST   = 6'd8;
	localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RST = 16'd250;
	localparam logic [BIT_COUNT_W-1:0]   DEFAULT_BITS    = 6'd8;

	// APB register map: one 32-bit register per 4 bytes
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_BIT_COUNT   = 1'b0;
	localparam logic REG_HALF_PERIOD = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_DATA
	} phase_t;

endpackage

// File: hdl/spi_master_length_prefixed_unit.sv
// Mode-0 SPI master that sends a length header, then exchanges the data bits.
// The result word for an input word is registered and shown on the cycle after
// it is taken. Throughput: one word per cycle while the result side drains, set by the
// single output register (a new word is taken whenever it is empty or drained).
// Reset (arst_n low, asynchronous): idle, no result pending, bit_count 8,
// half_period 250; the result outputs, cs_n among them, are not reset.
`timescale 1ns / 1ps

module spi_master_length_prefixed_unit #(
	parameter int MAX_BITS = splu_pkg::MAX_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// APB configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [splu_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [splu_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [splu_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	// input channel: one word per serial tick
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                start_req,
	input  logic [splu_pkg::DATA_W-1:0]         tx_data,
	input  logic                                miso,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                sclk,
	output logic                                mosi,
	output logic                                cs_n,
	output logic                                busy_res,
	output logic                                done_res,
	output logic [splu_pkg::DATA_W-1:0]         rx_data
);

	localparam int IDX_W  = splu_pkg::BIT_COUNT_W;
	localparam int TXI_W  = $clog2(MAX_BITS);
	localparam int HDRI_W = $clog2(splu_pkg::HEADER_BITS);
	localparam int HP_W   = splu_pkg::HALF_PERIOD_W;

	// configuration registers
	logic [splu_pkg::BIT_COUNT_W-1:0] bit_count_q;
	logic [HP_W-1:0]                  half_period_q;

	// transfer state
	splu_pkg::phase_t     phase_q, phase_d;
	logic [IDX_W-1:0]     idx_q, idx_d;
	logic [HP_W-1:0]      tick_q, tick_d;
	logic                 lvl_q, lvl_d;
	logic [MAX_BITS-1:0]  tx_q, tx_d;
	logic [MAX_BITS-1:0]  rx_q, rx_d;
	logic [IDX_W-1:0]     eff_q, eff_d;
	logic                 done_d;

	// result register
	logic                          out_valid_q;
	logic                          sclk_q, mosi_q, cs_n_q, busy_q, done_q;
	logic [splu_pkg::DATA_W-1:0]   rx_data_q;

	logic                          sclk_n, mosi_n, cs_n_n, busy_n;
	logic [splu_pkg::DATA_W-1:0]   rx_data_n;

	logic                 in_fire;
	logic                 cfg_wr;
	logic [HP_W-1:0]      hp_eff;
	logic [HP_W:0]        tick_inc;
	logic [IDX_W-1:0]     idx_inc;
	logic [IDX_W-1:0]     eff_sel;
	logic [MAX_BITS-1:0]  tx_ext;
	logic [MAX_BITS-1:0]  tx_load;
	logic [splu_pkg::HEADER_BITS-1:0] hdr_byte;
	logic [HDRI_W-1:0]    hdr_sel;
	logic [IDX_W-1:0]     data_sel;
	logic [63:0]          rx_ext;

	// --- handshakes ---
	// The result register frees up the same cycle it is drained.
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// --- APB configuration ---
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q   <= splu_pkg::BIT_COUNT_RST;
			half_period_q <= splu_pkg::HALF_PERIOD_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				splu_pkg::REG_BIT_COUNT:   bit_count_q   <= pwdata[splu_pkg::BIT_COUNT_W-1:0];
				splu_pkg::REG_HALF_PERIOD: half_period_q <= pwdata[HP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			splu_pkg::REG_BIT_COUNT:   prdata = splu_pkg::APB_DATA_W'(bit_count_q);
			splu_pkg::REG_HALF_PERIOD: prdata = splu_pkg::APB_DATA_W'(half_period_q);
			default:                   prdata = '0;
		endcase
	end

	// --- start-of-transfer capture ---
	// Out-of-range lengths (zero or above MAX_BITS) fall back to 8 bits.
	assign eff_sel = (bit_count_q != '0 && {1'b0, bit_count_q} <= (IDX_W + 1)'(MAX_BITS))
		? bit_count_q : splu_pkg::DEFAULT_BITS;
	assign tx_ext  = MAX_BITS'(tx_data);

	always_comb begin
		for (int i = 0; i < MAX_BITS; i++) begin
			tx_load[i] = tx_ext[i] && (i < int'(eff_sel));
		end
	end

	// A half period of zero counts as one tick.
	assign hp_eff   = (half_period_q == '0) ? HP_W'(1) : half_period_q;
	assign tick_inc = {1'b0, tick_q} + (HP_W + 1)'(1);
	assign idx_inc  = idx_q + IDX_W'(1);

	// --- next state ---
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		tick_d  = tick_q;
		lvl_d   = lvl_q;
		tx_d    = tx_q;
		rx_d    = rx_q;
		eff_d   = eff_q;
		done_d  = 1'b0;
		if (in_fire) begin
			case (phase_q)
				splu_pkg::PH_IDLE: begin
					if (start_req) begin
						eff_d   = eff_sel;
						tx_d    = tx_load;
						phase_d = splu_pkg::PH_HEADER;
						idx_d   = '0;
						tick_d  = '0;
						lvl_d   = 1'b0;
					end
				end
				splu_pkg::PH_HEADER, splu_pkg::PH_DATA: begin
					if (tick_inc >= {1'b0, hp_eff}) begin
						tick_d = '0;
						if (!lvl_q) begin
							lvl_d = 1'b1;
						end else begin
							// falling edge: bit complete
							lvl_d = 1'b0;
							if (phase_q == splu_pkg::PH_HEADER) begin
								if (int'(idx_inc) >= splu_pkg::HEADER_BITS) begin
									phase_d = splu_pkg::PH_DATA;
									idx_d   = '0;
									rx_d    = '0;
								end else begin
									idx_d = idx_inc;
								end
							end else begin
								rx_d = {rx_q[MAX_BITS-2:0], miso};
								if (idx_inc >= eff_q) begin
									phase_d = splu_pkg::PH_IDLE;
									idx_d   = '0;
									done_d  = 1'b1;
								end else begin
									idx_d = idx_inc;
								end
							end
						end
					end else begin
						tick_d = tick_inc[HP_W-1:0];
					end
				end
				default: phase_d = splu_pkg::PH_IDLE;
			endcase
		end
	end

	// --- result word from the updated state ---
	assign hdr_byte = splu_pkg::HEADER_BITS'(eff_d);
	assign hdr_sel  = HDRI_W'(splu_pkg::HEADER_BITS - 1) - idx_d[HDRI_W-1:0];
	assign data_sel = eff_d - IDX_W'(1) - idx_d;
	assign rx_ext   = 64'(rx_d);

	always_comb begin
		sclk_n    = 1'b0;
		mosi_n    = 1'b0;
		cs_n_n    = 1'b1;
		busy_n    = 1'b0;
		rx_data_n = rx_ext[splu_pkg::DATA_W-1:0];
		case (phase_d)
			splu_pkg::PH_HEADER: begin
				sclk_n = lvl_d;
				mosi_n = hdr_byte[hdr_sel];
				cs_n_n = 1'b0;
				busy_n = 1'b1;
			end
			splu_pkg::PH_DATA: begin
				sclk_n = lvl_d;
				mosi_n = (idx_d < eff_d) ? tx_d[data_sel[TXI_W-1:0]] : 1'b0;
				cs_n_n = 1'b0;
				busy_n = 1'b1;
			end
			default: ;
		endcase
	end

	// --- registers ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= splu_pkg::PH_IDLE;
			idx_q   <= '0;
			tick_q  <= '0;
			lvl_q   <= 1'b0;
			tx_q    <= '0;
			rx_q    <= '0;
			eff_q   <= splu_pkg::DEFAULT_BITS;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			tick_q  <= tick_d;
			lvl_q   <= lvl_d;
			tx_q    <= tx_d;
			rx_q    <= rx_d;
			eff_q   <= eff_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sclk_q    <= sclk_n;
			mosi_q    <= mosi_n;
			cs_n_q    <= cs_n_n;
			busy_q    <= busy_n;
			done_q    <= done_d;
			rx_data_q <= rx_data_n;
		end
	end

	assign sclk     = sclk_q;
	assign mosi     = mosi_q;
	assign cs_n     = cs_n_q;
	assign busy_res = busy_q;
	assign done_res = done_q;
	assign rx_data  = rx_data_q;

endmodule

// File: hdl/splu_checker.sv
// Port-level checks for the length-prefixed SPI master, bound to the top level.
`timescale 1ns / 1ps

module splu_port_checks (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        sclk,
	input logic                        mosi,
	input logic                        cs_n,
	input logic                        busy_res,
	input logic                        done_res,
	input logic [splu_pkg::DATA_W-1:0] rx_data
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rx_data) && $stable(cs_n))
		else $error("result word changed while stalled");

	// no new word taken while the result register is full and stalled
	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken over a stalled result");

	// idle bus levels
	a_idle_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cs_n |-> !busy_res && !sclk && !mosi)
		else $error("bus not idle while deselected");

	// select low exactly while busy
	a_busy_cs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (busy_res != cs_n))
		else $error("busy and chip select disagree");

	// a transfer ends deselected
	a_done_cs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> cs_n && !sclk)
		else $error("done without release of chip select");

endmodule

bind spi_master_length_prefixed_unit splu_port_checks u_splu_port_checks (.*);

// File: sim/splu_checker.sv
// Watches the length-prefixed SPI master, predicts each result word and compares it.
`timescale 1ns / 1ps

module splu_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [splu_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [splu_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [splu_pkg::APB_DATA_W-1:0] prdata,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic                            start_req,
	input  logic [splu_pkg::DATA_W-1:0]     tx_data,
	input  logic                            miso,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic                            sclk,
	input  logic                            mosi,
	input  logic                            cs_n,
	input  logic                            busy_res,
	input  logic                            done_res,
	input  logic [splu_pkg::DATA_W-1:0]     rx_data,
	output int                              fail_count,
	output int                              pending,
	output int                              xfers_done,
	output logic                            link_idle
);

	typedef struct packed {
		logic                        sclk;
		logic                        mosi;
		logic                        cs_n;
		logic                        busy;
		logic                        done;
		logic [splu_pkg::DATA_W-1:0] rx;
	} line_levels_t;

	// register copies
	logic [splu_pkg::BIT_COUNT_W-1:0]   cfg_bits;
	logic [splu_pkg::HALF_PERIOD_W-1:0] cfg_half;

	// serial engine state
	splu_pkg::phase_t                   ph;
	logic [5:0]                         bidx;
	logic [splu_pkg::HALF_PERIOD_W-1:0] tcnt;
	logic                               lvl;
	logic [splu_pkg::DATA_W-1:0]        txs;
	logic [splu_pkg::DATA_W-1:0]        rxs;
	logic [splu_pkg::BIT_COUNT_W-1:0]   eff;

	line_levels_t levels_due[$];
	int           mismatches;

	// One serial tick; returns the line levels after it.
	task automatic step_spi_master(input logic s, input logic [splu_pkg::DATA_W-1:0] d,
			input logic m, output line_levels_t r);
		logic [16:0]                      hp;
		logic [16:0]                      nxt;
		logic                             fin;
		logic [splu_pkg::HEADER_BITS-1:0] hdr;
		int                               k;
		hp  = (cfg_half == '0) ? 17'd1 : {1'b0, cfg_half};
		fin = 1'b0;
		if (ph == splu_pkg::PH_IDLE) begin
			if (s) begin
				eff  = (cfg_bits >= 1 && cfg_bits <= splu_pkg::MAX_BITS_DEF)
					? cfg_bits : splu_pkg::DEFAULT_BITS;
				txs  = (eff >= splu_pkg::DATA_W) ? d : d & ((32'd1 << eff) - 32'd1);
				ph   = splu_pkg::PH_HEADER;
				bidx = '0;
				tcnt = '0;
				lvl  = 1'b0;
			end
		end else begin
			nxt = {1'b0, tcnt} + 17'd1;
			if (nxt >= hp) begin
				tcnt = '0;
				if (!lvl) begin
					lvl = 1'b1;
				end else begin
					lvl = 1'b0;
					if (ph == splu_pkg::PH_DATA)
						rxs = {rxs[splu_pkg::DATA_W-2:0], m};
					bidx = bidx + 6'd1;
					if (ph == splu_pkg::PH_HEADER) begin
						if (bidx >= splu_pkg::HEADER_BITS) begin
							ph   = splu_pkg::PH_DATA;
							bidx = '0;
							rxs  = '0;
						end
					end else if (bidx >= eff) begin
						ph   = splu_pkg::PH_IDLE;
						bidx = '0;
						fin  = 1'b1;
					end
				end
			end else begin
				tcnt = nxt[splu_pkg::HALF_PERIOD_W-1:0];
			end
		end
		hdr    = splu_pkg::HEADER_BITS'(eff);
		r.mosi = 1'b0;
		if (ph == splu_pkg::PH_HEADER && bidx < splu_pkg::HEADER_BITS) begin
			r.mosi = hdr[splu_pkg::HEADER_BITS-1-int'(bidx)];
		end else if (ph == splu_pkg::PH_DATA && bidx < eff) begin
			k      = int'(eff) - 1 - int'(bidx);
			r.mosi = txs[k];
		end
		r.sclk = (ph == splu_pkg::PH_IDLE) ? 1'b0 : lvl;
		r.cs_n = (ph == splu_pkg::PH_IDLE);
		r.busy = (ph != splu_pkg::PH_IDLE);
		r.done = fin;
		r.rx   = rxs;
	endtask

	task automatic note_bad(input string what, input logic [splu_pkg::DATA_W-1:0] want,
			input logic [splu_pkg::DATA_W-1:0] got);
		mismatches++;
		fail_count++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch, expected %0h got %0h", $realtime, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		line_levels_t                  want;
		line_levels_t                  nxt_lv;
		logic [splu_pkg::APB_DATA_W-1:0] rd_want;
		if (!arst_n) begin
			cfg_bits   = splu_pkg::BIT_COUNT_RST;
			cfg_half   = splu_pkg::HALF_PERIOD_RST;
			ph         = splu_pkg::PH_IDLE;
			bidx       = '0;
			tcnt       = '0;
			lvl        = 1'b0;
			txs        = '0;
			rxs        = '0;
			eff        = splu_pkg::DEFAULT_BITS;
			levels_due.delete();
			fail_count = 0;
			mismatches = 0;
			xfers_done = 0;
			pending    = 0;
			link_idle  = 1'b1;
		end else begin
			// result side first: it belongs to an earlier word
			if (out_valid && out_ready) begin
				if (levels_due.size() == 0) begin
					note_bad("unexpected result word", '0, rx_data);
				end else begin
					want = levels_due.pop_front();
					if (sclk !== want.sclk)
						note_bad("sclk", splu_pkg::DATA_W'(want.sclk), splu_pkg::DATA_W'(sclk));
					if (mosi !== want.mosi)
						note_bad("mosi", splu_pkg::DATA_W'(want.mosi), splu_pkg::DATA_W'(mosi));
					if (cs_n !== want.cs_n)
						note_bad("cs_n", splu_pkg::DATA_W'(want.cs_n), splu_pkg::DATA_W'(cs_n));
					if (busy_res !== want.busy)
						note_bad("busy_res", splu_pkg::DATA_W'(want.busy),
							splu_pkg::DATA_W'(busy_res));
					if (done_res !== want.done)
						note_bad("done_res", splu_pkg::DATA_W'(want.done),
							splu_pkg::DATA_W'(done_res));
					if (rx_data !== want.rx)
						note_bad("rx_data", want.rx, rx_data);
				end
			end
			// register read-back shows the value held before this edge
			rd_want = (paddr[splu_pkg::APB_ADDR_W-1:2] == splu_pkg::REG_BIT_COUNT)
				? splu_pkg::APB_DATA_W'(cfg_bits) : splu_pkg::APB_DATA_W'(cfg_half);
			if (prdata !== rd_want)
				note_bad("prdata", rd_want, prdata);
			if (in_valid && in_ready) begin
				step_spi_master(start_req, tx_data, miso, nxt_lv);
				levels_due.push_back(nxt_lv);
				if (nxt_lv.done)
					xfers_done++;
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[splu_pkg::APB_ADDR_W-1:2] == splu_pkg::REG_BIT_COUNT)
					cfg_bits = pwdata[splu_pkg::BIT_COUNT_W-1:0];
				else
					cfg_half = pwdata[splu_pkg::HALF_PERIOD_W-1:0];
			end
			pending   = levels_due.size();
			link_idle = (ph == splu_pkg::PH_IDLE);
		end
	end

endmodule

// File: sim/tb_top.sv
// Stimulus and verdict for the length-prefixed SPI master regression.
`timescale 1ns / 1ps

module tb_top;

	// Cycles with no word, result or register access before the run is called hung.
	localparam int STALL_LIMIT = 2000;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [splu_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [splu_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [splu_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	logic                            start_req = 1'b0;
	logic [splu_pkg::DATA_W-1:0]     tx_data = '0;
	logic                            miso = 1'b0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic                            sclk;
	logic                            mosi;
	logic                            cs_n;
	logic                            busy_res;
	logic                            done_res;
	logic [splu_pkg::DATA_W-1:0]     rx_data;

	int   fail_count;
	int   pending;
	int   xfers_done;
	logic link_idle;

	// Set while both sides run flat out; otherwise each side idles about 20% of cycles.
	bit   steady = 1'b0;
	// Registered at each rising edge: the word on the input channel was taken.
	logic word_taken = 1'b0;
	int   words_sent = 0;
	int   reg_writes = 0;
	int   quiet_cycles = 0;

	always #1 clk = ~clk;

	spi_master_length_prefixed_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.start_req(start_req), .tx_data(tx_data), .miso(miso),
		.out_valid(out_valid), .out_ready(out_ready),
		.sclk(sclk), .mosi(mosi), .cs_n(cs_n), .busy_res(busy_res), .done_res(done_res),
		.rx_data(rx_data)
	);

	splu_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.start_req(start_req), .tx_data(tx_data), .miso(miso),
		.out_valid(out_valid), .out_ready(out_ready),
		.sclk(sclk), .mosi(mosi), .cs_n(cs_n), .busy_res(busy_res), .done_res(done_res),
		.rx_data(rx_data),
		.fail_count(fail_count), .pending(pending), .xfers_done(xfers_done),
		.link_idle(link_idle)
	);

	always @(posedge clk) begin
		word_taken <= in_valid && in_ready;
	end

	// Result-side back-pressure, changed at the falling edge.
	always @(negedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 20);
	end

	// Hang detector: counts cycles in which nothing moves.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("spi_master_length_prefixed_unit regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One serial tick. Entered and left at a falling edge; valid stays high
	// after acceptance so the caller decides whether the next word follows.
	task automatic send_tick(input logic s, input logic [splu_pkg::DATA_W-1:0] d,
			input logic m);
		if (!steady && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid  <= 1'b1;
		start_req <= s;
		tx_data   <= d;
		miso      <= m;
		do @(negedge clk); while (!word_taken);
		words_sent++;
	endtask

	// Ticks with start low: the engine just idles (or keeps running).
	task automatic idle_ticks(input int n);
		repeat (n) send_tick(1'b0, $urandom, 1'($urandom_range(1)));
	endtask

	// Tick until the predicted engine is idle again.
	// miso_mode: 0 all zeros, 1 all ones, else random. hold_start keeps start
	// high through busy ticks and the done tick.
	task automatic finish_transfer(input bit hold_start, input int miso_mode);
		logic m;
		m = (miso_mode == 1);
		while (!link_idle) begin
			if (miso_mode > 1)
				m = 1'($urandom_range(1));
			send_tick(hold_start || ($urandom_range(99) < 10), $urandom, m);
		end
	endtask

	// Start a transfer and run it to the end.
	task automatic run_transfer(input logic [splu_pkg::DATA_W-1:0] word, input bit hold_start,
			input int miso_mode);
		logic m;
		m = (miso_mode == 1);
		send_tick(1'b1, word, (miso_mode > 1) ? 1'($urandom_range(1)) : m);
		finish_transfer(hold_start, miso_mode);
	endtask

	// Drop valid and wait until every expected word is back.
	task automatic drain;
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic reg_write(input logic idx, input logic [splu_pkg::APB_DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk) penable <= 1'b1;
		@(negedge clk) begin
			psel    <= 1'b0;
			penable <= 1'b0;
			pwrite  <= 1'b0;
		end
		@(negedge clk);
		reg_writes++;
	endtask

	// Reconfigure between transfers; the unused upper bits carry noise.
	task automatic set_regs(input logic [splu_pkg::BIT_COUNT_W-1:0] bits,
			input logic [splu_pkg::HALF_PERIOD_W-1:0] half);
		logic [splu_pkg::APB_DATA_W-1:0] v;
		drain();
		v = $urandom;
		v[splu_pkg::BIT_COUNT_W-1:0] = bits;
		reg_write(splu_pkg::REG_BIT_COUNT, v);
		v = $urandom;
		v[splu_pkg::HALF_PERIOD_W-1:0] = half;
		reg_write(splu_pkg::REG_HALF_PERIOD, v);
	endtask

	initial begin
		int                                 rand_start;
		logic [splu_pkg::BIT_COUNT_W-1:0]   bits;
		logic [splu_pkg::HALF_PERIOD_W-1:0] half;

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, at full rate first: the long stretch with no idling.
		// Reset settings (8 bits, half period 250): start with start noise on top
		// through part of the first low half, then speed the clock up mid-transfer.
		steady = 1'b1;
		idle_ticks(2);
		send_tick(1'b1, 32'hFFFF_FFFF, 1'($urandom_range(1)));
		repeat (29) send_tick(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
		drain();
		reg_write(splu_pkg::REG_HALF_PERIOD, 32'd1);
		finish_transfer(1'b0, 2);

		// Longest legal length.
		set_regs(6'd32, 16'd1);
		run_transfer(32'hA5A5_5A5A, 1'b0, 2);
		steady = 1'b0;

		// Shortest transfer, zero half period acting as one, miso all ones.
		set_regs(6'd1, 16'd0);
		run_transfer(32'hFFFF_FFFF, 1'b0, 1);

		// Out-of-range lengths fall back to 8: zero, just past the max, all ones.
		set_regs(6'd0, 16'd1);
		run_transfer(32'h1234_5678, 1'b0, 0);
		set_regs(6'd33, 16'd1);
		run_transfer($urandom, 1'b0, 2);
		set_regs(6'd63, 16'd0);
		// Start held high through the busy ticks and the done tick, then a
		// back-to-back start on the very next tick.
		run_transfer($urandom, 1'b1, 2);
		run_transfer($urandom, 1'b1, 2);
		idle_ticks(3);

		// Random part: short half periods, mostly legal lengths, some noise.
		rand_start = words_sent;
		while (words_sent - rand_start < 70) begin
			bits = ($urandom_range(99) < 70)
				? splu_pkg::BIT_COUNT_W'($urandom_range(1, splu_pkg::MAX_BITS_DEF))
				: splu_pkg::BIT_COUNT_W'($urandom_range(0, 63));
			half = splu_pkg::HALF_PERIOD_W'($urandom_range(0, 3));
			set_regs(bits, half);
			steady = ($urandom_range(4) == 0);
			repeat ($urandom_range(1, 2)) begin
				idle_ticks($urandom_range(0, 3));
				run_transfer($urandom, $urandom_range(9) == 0, 2);
			end
			steady = 1'b0;
		end

		// Largest half period: far too slow to finish, so it runs last and
		// just shows the first low half with start noise on top.
		set_regs(6'd32, 16'hFFFF);
		send_tick(1'b1, $urandom, 1'($urandom_range(1)));
		repeat (40) send_tick(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));

		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);

		$display("Run covered %0d words, %0d finished transfers, %0d register writes.",
			words_sent, xfers_done, reg_writes);
		$display("Lengths 0..63 with fallback, half periods 0..3, 250 and 65535, start held while busy.");
		if (fail_count == 0 && pending == 0) begin
			$display("spi_master_length_prefixed_unit regression: pass");
		end else begin
			$display("spi_master_length_prefixed_unit regression: fail");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/splu_pkg.sv
hdl/spi_master_length_prefixed_unit.sv
hdl/splu_checker.sv
sim/splu_checker.sv
sim/tb_top.sv
